### rtl/core/gbet_pkg.sv
`timescale 1ns / 1ps

package gbet_pkg;

    // Controller slots in use (1 to 4); the stores are sized for four.
    localparam int NUM_PADS      = 4;
    localparam int MAX_PADS      = 4;
    localparam int BTNS_PER_PAD  = 8;
    localparam int BTN_DEPTH     = MAX_PADS * BTNS_PER_PAD;
    localparam logic [15:0] DEADZONE_RESET = 16'd10;

    // Four-state record encoding
    localparam logic [1:0] ST_OFF      = 2'd0;
    localparam logic [1:0] ST_ON       = 2'd1;
    localparam logic [1:0] ST_PRESSED  = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    // Event codes
    localparam logic [2:0] FN_PRESS       = 3'd0;
    localparam logic [2:0] FN_RELEASE     = 3'd1;
    localparam logic [2:0] FN_AXIS        = 3'd2;
    localparam logic [2:0] FN_TICK        = 3'd3;
    localparam logic [2:0] FN_RELEASE_ALL = 3'd4;
    localparam logic [2:0] FN_CONNECT     = 3'd5;
    localparam logic [2:0] FN_DISCONNECT  = 3'd6;

    // Button codes
    localparam logic [3:0] BTN_UP    = 4'd0;
    localparam logic [3:0] BTN_RIGHT = 4'd1;
    localparam logic [3:0] BTN_DOWN  = 4'd2;
    localparam logic [3:0] BTN_LEFT  = 4'd3;
    localparam logic [3:0] BTN_PAUSE = 4'd8;

    typedef struct packed {
        logic [15:0] axis_value;
        logic        axis_select;
        logic [3:0]  button;
        logic [1:0]  controller;
        logic [2:0]  func;
    } gbet_item_t;

    typedef struct packed {
        logic [1:0] assigned_slot;
        logic [1:0] link_state;
        logic [1:0] button_state;
    } gbet_result_t;

    function automatic logic [1:0] press_f(input logic [1:0] s);
        press_f = (s == ST_OFF || s == ST_RELEASED) ? ST_PRESSED : s;
    endfunction

    function automatic logic [1:0] release_f(input logic [1:0] s);
        release_f = (s == ST_ON || s == ST_PRESSED) ? ST_RELEASED : s;
    endfunction

    function automatic logic [1:0] settle_f(input logic [1:0] s);
        unique case (s)
            ST_PRESSED:  settle_f = ST_ON;
            ST_RELEASED: settle_f = ST_OFF;
            default:     settle_f = s;
        endcase
    endfunction

    function automatic logic slot_ok_f(input logic [1:0] c);
        slot_ok_f = ({1'b0, c} < 3'(NUM_PADS));
    endfunction

endpackage

### rtl/core/gbet_store.sv
`timescale 1ns / 1ps

module gbet_store
    import gbet_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  gbet_item_t   item,
    input  logic [15:0]  deadzone,
    output gbet_result_t result
);

    logic [1:0] btn_reg   [BTN_DEPTH];
    logic [1:0] btn_next  [BTN_DEPTH];
    logic [1:0] pause_reg [MAX_PADS];
    logic [1:0] pause_next[MAX_PADS];
    logic [1:0] link_reg  [MAX_PADS];
    logic [1:0] link_next [MAX_PADS];

    logic        neg;
    logic [15:0] mag;
    logic        in_dz;
    logic [2:0]  pos_btn;
    logic [2:0]  neg_btn;
    logic [2:0]  hit_btn;
    logic [1:0]  assigned;
    logic [1:0]  link_slot;

    assign neg     = item.axis_value[15];
    assign mag     = neg ? (16'd0 - item.axis_value) : item.axis_value;
    assign in_dz   = (mag < deadzone);
    assign pos_btn = item.axis_select ? BTN_DOWN[2:0] : BTN_RIGHT[2:0];
    assign neg_btn = item.axis_select ? BTN_UP[2:0] : BTN_LEFT[2:0];
    assign hit_btn = neg ? neg_btn : pos_btn;

    // First free slot for a connect; slot 0 if all are taken
    always_comb
    begin
        assigned = 2'd0;
        for (int i = NUM_PADS - 1; i >= 0; i--)
        begin
            if (link_reg[i] == ST_OFF || link_reg[i] == ST_RELEASED)
            begin
                assigned = 2'(i);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < BTN_DEPTH; k++)
        begin
            logic       pad_hit;
            logic [2:0] j;
            pad_hit     = (item.controller == 2'(k / BTNS_PER_PAD));
            j           = 3'(k % BTNS_PER_PAD);
            btn_next[k] = btn_reg[k];
            if (k < NUM_PADS * BTNS_PER_PAD)
            begin
                unique case (item.func)
                    FN_PRESS:
                        if (pad_hit && item.button == {1'b0, j})
                            btn_next[k] = press_f(btn_reg[k]);
                    FN_RELEASE:
                        if (pad_hit && item.button == {1'b0, j})
                            btn_next[k] = release_f(btn_reg[k]);
                    FN_AXIS:
                        if (pad_hit)
                        begin
                            if (in_dz)
                            begin
                                if (j == pos_btn || j == neg_btn)
                                    btn_next[k] = release_f(btn_reg[k]);
                            end
                            else if (j == hit_btn)
                            begin
                                btn_next[k] = press_f(btn_reg[k]);
                            end
                        end
                    FN_TICK:
                        btn_next[k] = settle_f(btn_reg[k]);
                    FN_RELEASE_ALL:
                        btn_next[k] = release_f(btn_reg[k]);
                    default:
                        btn_next[k] = btn_reg[k];
                endcase
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < MAX_PADS; c++)
        begin
            logic pad_hit;
            pad_hit       = (item.controller == 2'(c)) && (c < NUM_PADS);
            pause_next[c] = pause_reg[c];
            link_next[c]  = link_reg[c];
            unique case (item.func)
                FN_PRESS:
                    if (pad_hit && item.button == BTN_PAUSE)
                        pause_next[c] = press_f(pause_reg[c]);
                FN_RELEASE:
                    if (pad_hit && item.button == BTN_PAUSE)
                        pause_next[c] = release_f(pause_reg[c]);
                FN_TICK:
                    if (c < NUM_PADS)
                        link_next[c] = settle_f(link_reg[c]);
                FN_CONNECT:
                    if (assigned == 2'(c))
                        link_next[c] = ST_PRESSED;
                FN_DISCONNECT:
                    if (pad_hit)
                        link_next[c] = ST_RELEASED;
                default:
                    link_next[c] = link_reg[c];
            endcase
        end
    end

    // Result reads the records as they stand after this event
    assign link_slot = (item.func == FN_CONNECT) ? assigned : item.controller;

    always_comb
    begin
        result = '0;
        if (slot_ok_f(item.controller))
        begin
            if (item.button < BTN_PAUSE)
                result.button_state = btn_next[{item.controller, item.button[2:0]}];
            else if (item.button == BTN_PAUSE)
                result.button_state = pause_next[item.controller];
        end
        if (slot_ok_f(link_slot))
            result.link_state = link_next[link_slot];
        if (item.func == FN_CONNECT)
            result.assigned_slot = assigned;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BTN_DEPTH; k++)
                btn_reg[k] <= ST_OFF;
            for (int c = 0; c < MAX_PADS; c++)
            begin
                pause_reg[c] <= ST_OFF;
                link_reg[c]  <= ST_OFF;
            end
        end
        else if (step)
        begin
            for (int k = 0; k < BTN_DEPTH; k++)
                btn_reg[k] <= btn_next[k];
            for (int c = 0; c < MAX_PADS; c++)
            begin
                pause_reg[c] <= pause_next[c];
                link_reg[c]  <= link_next[c];
            end
        end
    end

endmodule

### rtl/core/gamepad_button_edge_tracker_unit.sv
`timescale 1ns / 1ps

// Button edge tracker for four controllers. Takes one event per clock on
// the slave stream while the master side keeps tready high, and returns
// one result per event on the master stream through an input register and
// then a result register. All 40 two-bit records update together in the
// cycle an event leaves the input register, so the sustained rate is one
// event per cycle while the master side keeps tready high. The deadzone
// register may be written only while no event is in flight.
module gamepad_button_edge_tracker_unit
    import gbet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // axis_deadzone

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // controller, button, axis_select, axis_value, pad
    input  logic [2:0]  s_tuser,        // func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata         // button_state, link_state, assigned_slot, pad
);

    logic [15:0]  deadzone_reg;
    logic         in_valid_reg;
    gbet_item_t   in_item_reg;
    logic         out_valid_reg;
    gbet_result_t out_data_reg;
    gbet_result_t result;
    logic         advance;

    // Event moves to the result register when that register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadzone_reg <= DEADZONE_RESET;
        else if (cfg_we)
            deadzone_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.func        <= s_tuser;
            in_item_reg.controller  <= s_tdata[1:0];
            in_item_reg.button      <= s_tdata[5:2];
            in_item_reg.axis_select <= s_tdata[6];
            in_item_reg.axis_value  <= s_tdata[22:7];
        end
        if (advance)
            out_data_reg <= result;
    end

    gbet_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (in_item_reg),
        .deadzone (deadzone_reg),
        .result   (result)
    );

endmodule

### sim/tb_gamepad_button_edge_tracker_unit.sv
`timescale 1ns / 1ps

module tb_gamepad_button_edge_tracker_unit;
    import gbet_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // Model of the block's records
    logic [1:0]  btn_rec [BTN_DEPTH];
    logic [1:0]  pause_rec [MAX_PADS];
    logic [1:0]  link_rec [MAX_PADS];
    logic [15:0] deadzone_q;

    gbet_result_t pending_results[$];
    int error_count = 0;
    int result_count = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int rx_pick;
    int rx_stall_len;

    gamepad_button_edge_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),       // controller, button, axis_select, axis_value, pad
        .s_tuser   (s_tuser),       // func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)        // button_state, link_state, assigned_slot, pad
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Record tracking model
    // ------------------------------------------------------------------
    function automatic logic [1:0] settled(input logic [1:0] s);
        if (s == ST_PRESSED)
            return ST_ON;
        if (s == ST_RELEASED)
            return ST_OFF;
        return s;
    endfunction

    function automatic logic [1:0] moved(input logic [1:0] s, input bit pressing);
        if (pressing && (s == ST_OFF || s == ST_RELEASED))
            return ST_PRESSED;
        if (!pressing && (s == ST_ON || s == ST_PRESSED))
            return ST_RELEASED;
        return s;
    endfunction

    function automatic void button_update(input int c, input int b, input bit pressing);
        if (c < NUM_PADS)
        begin
            if (b < BTNS_PER_PAD)
                btn_rec[c * BTNS_PER_PAD + b] = moved(btn_rec[c * BTNS_PER_PAD + b], pressing);
            else if (b == int'(BTN_PAUSE))
                pause_rec[c] = moved(pause_rec[c], pressing);
        end
    endfunction

    function automatic gbet_result_t track_event(input logic [2:0] fn, input logic [1:0] c,
                                                 input logic [3:0] b, input logic ax,
                                                 input logic [15:0] val);
        gbet_result_t res;
        logic [16:0]  mag;
        int           pos_btn;
        int           neg_btn;
        int           link_slot;
        int           slot;
        bit           found;
        link_slot = int'(c);
        slot = 0;
        found = 1'b0;
        case (fn)
            FN_PRESS:   button_update(int'(c), int'(b), 1'b1);
            FN_RELEASE: button_update(int'(c), int'(b), 1'b0);
            FN_AXIS:
            begin
                mag = val[15] ? 17'h10000 - {1'b0, val} : {1'b0, val};
                pos_btn = ax ? int'(BTN_DOWN) : int'(BTN_RIGHT);
                neg_btn = ax ? int'(BTN_UP) : int'(BTN_LEFT);
                if (mag < {1'b0, deadzone_q})
                begin
                    button_update(int'(c), pos_btn, 1'b0);
                    button_update(int'(c), neg_btn, 1'b0);
                end
                else
                    button_update(int'(c), val[15] ? neg_btn : pos_btn, 1'b1);
            end
            FN_TICK:
                for (int i = 0; i < NUM_PADS; i++)
                begin
                    link_rec[i] = settled(link_rec[i]);
                    for (int j = 0; j < BTNS_PER_PAD; j++)
                        btn_rec[i * BTNS_PER_PAD + j] = settled(btn_rec[i * BTNS_PER_PAD + j]);
                end
            FN_RELEASE_ALL:
                for (int i = 0; i < NUM_PADS; i++)
                    for (int j = 0; j < BTNS_PER_PAD; j++)
                        button_update(i, j, 1'b0);
            FN_CONNECT:
            begin
                // first free slot, slot 0 when all are taken
                for (int i = 0; i < NUM_PADS; i++)
                    if (!found && (link_rec[i] == ST_OFF || link_rec[i] == ST_RELEASED))
                    begin
                        slot = i;
                        found = 1'b1;
                    end
                link_rec[slot] = ST_PRESSED;
                link_slot = slot;
            end
            FN_DISCONNECT:
                if (int'(c) < NUM_PADS)
                    link_rec[c] = ST_RELEASED;
            default: ;
        endcase

        res.button_state = ST_OFF;
        if (int'(c) < NUM_PADS)
        begin
            if (int'(b) < BTNS_PER_PAD)
                res.button_state = btn_rec[int'(c) * BTNS_PER_PAD + int'(b)];
            else if (b == BTN_PAUSE)
                res.button_state = pause_rec[c];
        end
        res.link_state = (link_slot < NUM_PADS) ? link_rec[link_slot] : ST_OFF;
        res.assigned_slot = 2'(slot);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_event(input logic [2:0] fn, input logic [1:0] c, input logic [3:0] b,
                              input logic ax, input logic [15:0] val);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {1'b0, val, ax, b, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(track_event(fn, c, b, ax, val));
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_deadzone(input logic [15:0] dz);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= dz;
        @(negedge clk);
        cfg_we <= 1'b0;
        deadzone_q = dz;
    endtask

    task automatic report_mismatch(input string field, input logic [1:0] got,
                                   input logic [1:0] want);
        $display("result %0d: %s got %0d expected %0d", result_count, field, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_press_release();
        send_event(FN_TICK, 2'd0, BTN_UP, 1'b0, 16'h0000);         // untouched after reset
        send_event(FN_PRESS, 2'd0, BTN_UP, 1'b0, 16'h0000);
        send_event(FN_PRESS, 2'd0, BTN_UP, 1'b0, 16'h0000);        // already pressed
        send_event(FN_RELEASE, 2'd0, BTN_UP, 1'b0, 16'h0000);
        send_event(FN_PRESS, 2'd0, BTN_UP, 1'b0, 16'h0000);        // just released back
        send_event(FN_TICK, 2'd0, BTN_UP, 1'b0, 16'h0000);
        send_event(FN_RELEASE, 2'd0, BTN_UP, 1'b0, 16'h0000);
        send_event(FN_PRESS, 2'd3, BTN_PAUSE, 1'b1, 16'hFFFF);
        send_event(FN_TICK, 2'd3, BTN_PAUSE, 1'b0, 16'h0000);      // pause not settled
        send_event(FN_PRESS, 2'd3, 4'd15, 1'b0, 16'h0000);         // button out of range
        drain();
    endtask

    task automatic test_axis();
        // deadzone still at its reset value
        send_event(FN_AXIS, 2'd1, BTN_RIGHT, 1'b0, 16'd9);
        send_event(FN_AXIS, 2'd1, BTN_RIGHT, 1'b0, 16'd10);
        send_event(FN_AXIS, 2'd1, BTN_LEFT, 1'b0, 16'h8000);
        send_event(FN_AXIS, 2'd1, BTN_DOWN, 1'b1, 16'h7FFF);
        send_event(FN_AXIS, 2'd1, BTN_UP, 1'b1, 16'hFFF6);
        send_event(FN_AXIS, 2'd1, BTN_UP, 1'b1, 16'h0000);
        drain();
    endtask

    task automatic test_release_all();
        send_event(FN_RELEASE_ALL, 2'd1, BTN_LEFT, 1'b0, 16'h0000);
        send_event(FN_RELEASE_ALL, 2'd3, BTN_PAUSE, 1'b0, 16'h0000);
        drain();
    endtask

    task automatic test_links();
        repeat (5)
            send_event(FN_CONNECT, 2'd2, 4'd4, 1'b0, 16'h0000);    // last one finds no free slot
        send_event(FN_DISCONNECT, 2'd2, 4'd7, 1'b0, 16'h0000);
        send_event(FN_CONNECT, 2'd0, 4'd9, 1'b0, 16'h0000);
        send_event(3'd7, 2'd1, 4'd5, 1'b1, 16'h1234);              // unused code
        drain();
    endtask

    task automatic random_event();
        logic [2:0]  fn;
        logic [3:0]  b;
        logic [15:0] val;
        int          r;
        int          m;
        r = $urandom_range(0, 99);
        if (r < 28)      fn = FN_PRESS;
        else if (r < 48) fn = FN_RELEASE;
        else if (r < 64) fn = FN_AXIS;
        else if (r < 79) fn = FN_TICK;
        else if (r < 83) fn = FN_RELEASE_ALL;
        else if (r < 90) fn = FN_CONNECT;
        else if (r < 97) fn = FN_DISCONNECT;
        else             fn = 3'd7;
        b = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        case ($urandom_range(0, 3))
            0: val = 16'($urandom);
            1:
            begin
                // straddle the deadzone edge
                m = int'(deadzone_q) + $urandom_range(0, 4) - 2;
                if (m < 0)
                    m = 0;
                if (m > 32768)
                    m = 32768;
                val = $urandom_range(0, 1) ? 16'(65536 - m) : 16'(m);
            end
            2:
            begin
                case ($urandom_range(0, 4))
                    0: val = 16'h8000;
                    1: val = 16'h7FFF;
                    2: val = 16'h0000;
                    3: val = 16'hFFFF;
                    default: val = 16'h0001;
                endcase
            end
            default: val = 16'($urandom_range(0, 40) - 20);
        endcase
        send_event(fn, 2'($urandom_range(0, 3)), b, 1'($urandom_range(0, 1)), val);
    endtask

    task automatic test_random_traffic(input int count, input logic [15:0] dz,
                                       input bit gaps, input bit stalls);
        set_deadzone(dz);
        gaps_on = gaps;
        stalls_on = stalls;
        for (int n = 0; n < count; n++)
        begin
            random_event();
            if (n % 70 == 69)
                drain();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        gbet_result_t got;
        gbet_result_t want;
        if (m_tvalid && m_tready)
        begin
            got = gbet_result_t'(m_tdata[5:0]);
            if (pending_results.size() == 0)
            begin
                $display("result %0d: unexpected transfer, data %h", result_count, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.button_state !== want.button_state)
                    report_mismatch("button_state", got.button_state, want.button_state);
                if (got.link_state !== want.link_state)
                    report_mismatch("link_state", got.link_state, want.link_state);
                if (got.assigned_slot !== want.assigned_slot)
                    report_mismatch("assigned_slot", got.assigned_slot, want.assigned_slot);
            end
            result_count++;
        end
    end

    always
    begin
        @(negedge clk);
        rx_pick = $urandom_range(0, 99);
        if (!rst_n || !stalls_on || rx_pick < 55)
            m_tready <= 1'b1;
        else
        begin
            rx_stall_len = (rx_pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
            m_tready <= 1'b0;
            repeat (rx_stall_len - 1)
                @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        foreach (btn_rec[i])
            btn_rec[i] = ST_OFF;
        foreach (pause_rec[i])
            pause_rec[i] = ST_OFF;
        foreach (link_rec[i])
            link_rec[i] = ST_OFF;
        deadzone_q = DEADZONE_RESET;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_press_release();
        test_axis();
        test_release_all();
        test_links();
        test_random_traffic(150, DEADZONE_RESET, 1'b1, 1'b1);
        test_random_traffic(150, 16'd0, 1'b1, 1'b1);
        test_random_traffic(150, 16'd32768, 1'b0, 1'b0);
        test_random_traffic(150, 16'($urandom_range(1, 2000)), 1'b1, 1'b1);

        repeat (4)
            @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
rtl/core/gbet_pkg.sv
rtl/core/gbet_store.sv
rtl/core/gamepad_button_edge_tracker_unit.sv
sim/tb_gamepad_button_edge_tracker_unit.sv
